// File: rtl/nse_pkg.sv
// Shared types and constants for the Nash-Sutcliffe efficiency block.
package nse_pkg;

	localparam int MAX_SAMPLES_DEF = 512;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int FIELD_W  = 16;
	localparam int IN_DATA_W = 32;
	localparam int EFF_W    = 24;
	localparam int STAT_W   = 2;
	localparam int QUOT_W   = 26;
	localparam int FRAC_W   = 16;

	localparam int SKIP_W = 9;
	localparam logic [SKIP_W-1:0] SKIP_RESET = 9'd50;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 1;
	localparam logic [REG_IDX_W-1:0] REG_SKIP_COUNT = 1'b0;

	localparam logic signed [QUOT_W+1:0] ONE_Q16 = (QUOT_W+2)'(65536);
	localparam logic signed [QUOT_W+1:0] EFF_MIN = -(QUOT_W+2)'(8388608);

	typedef enum logic [STAT_W-1:0] {
		STAT_OK   = 2'd0,
		STAT_FEW  = 2'd1,
		STAT_FLAT = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_MUL,
		ST_PREP,
		ST_CHECK,
		ST_DIV,
		ST_WAIT
	} state_t;

	typedef struct packed {
		logic take;
		logic mul;
		logic prep;
		logic init;
		logic step;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic early;
		logic div_last;
		logic out_busy;
	} sts_t;

endpackage

// File: rtl/nash_sutcliffe_efficiency_top.sv
// Nash-Sutcliffe efficiency of a paired series: top level.
//
// Input stream: one (simulated, observed) pair per transaction, tlast on the final
// pair of a series. The first skip_count pairs of a series (APB register at 0x0,
// reset 50) are left out; pairs beyond MAX_SAMPLES are ignored.
// Non-final pairs are taken one per cycle; each updates sum(o), sum(o^2), sum(e^2).
// After the final pair s_tready stays low while the block forms
// D = n*sum(o^2) - sum(o)^2 and N = n*sum(e^2) and runs a restoring divider,
// one quotient bit per cycle over the scaled numerator.
// The final pair passes the accumulate stage; the products, the subtraction and the
// check follow in turn, then the divider; too few pairs or zero variance skip the
// divider and go straight to the result register.
// Output stream: one transaction per series: efficiency in Q8.16 and a status code
// (0 ok, 1 too few pairs, 2 zero observed variance).
// The result register holds its value while m_tready is low; new pairs are still
// taken meanwhile, and the next series result waits for that register to drain.
// Reset clears the accumulators, the sequencer and the output valid flag, and
// restores skip_count to 50.
module nash_sutcliffe_efficiency_top #(
	parameter int MAX_SAMPLES = nse_pkg::MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = nse_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [nse_pkg::IN_DATA_W-1:0]     s_tdata,   // sim_sample, obs_sample
	input  logic                              s_tlast,   // last_pair
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [nse_pkg::EFF_W-1:0]         m_tdata,   // efficiency
	output logic [nse_pkg::STAT_W-1:0]        m_tuser,   // status
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [nse_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [nse_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [nse_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready
);
	import nse_pkg::*;

	logic [SKIP_W-1:0] skip_count;
	cmd_t              cmd;
	sts_t              sts;

	nse_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.skip_count (skip_count)
	);

	nse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	nse_dp #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.sim_sample (s_tdata[FIELD_W-1:0]),
		.obs_sample (s_tdata[2*FIELD_W-1:FIELD_W]),
		.skip_count (skip_count),
		.cmd        (cmd),
		.sts        (sts),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.efficiency (m_tdata),
		.status     (m_tuser)
	);

endmodule

// File: rtl/nse_regs.sv
// APB register file holding the skip count.
module nse_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [nse_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [nse_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [nse_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	output logic [nse_pkg::SKIP_W-1:0]        skip_count
);
	import nse_pkg::*;

	logic [SKIP_W-1:0]    skip_q;
	logic [REG_IDX_W-1:0] idx;

	assign idx    = paddr[APB_ADDR_W-1:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= SKIP_RESET;
		end else if (psel && penable && pwrite && pready && idx == REG_SKIP_COUNT) begin
			skip_q <= pwdata[SKIP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (idx == REG_SKIP_COUNT) begin
			prdata = APB_DATA_W'(skip_q);
		end
	end

	assign skip_count = skip_q;

endmodule

// File: rtl/nse_ctrl.sv
// Sequencer: accumulate phase, final products, long division, result handoff.
module nse_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic          s_tlast,
	output logic          s_tready,
	input  nse_pkg::sts_t sts,
	output nse_pkg::cmd_t cmd
);
	import nse_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		s_tready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.take = s_tvalid;
				if (s_tvalid && s_tlast) begin
					state_nxt = ST_ACC;
				end
			end
			// last pair is still in the accumulate stage
			ST_ACC: begin
				state_nxt = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep  = 1'b1;
				state_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.init  = 1'b1;
				state_nxt = sts.early ? ST_WAIT : ST_DIV;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (sts.div_last) begin
					state_nxt = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (!sts.out_busy) begin
					cmd.load  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/nse_dp.sv
// Datapath: sample accumulators, final products, restoring divider, output register.
module nse_dp #(
	parameter int MAX_SAMPLES = nse_pkg::MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = nse_pkg::SAMPLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [nse_pkg::FIELD_W-1:0]    sim_sample,
	input  logic [nse_pkg::FIELD_W-1:0]    obs_sample,
	input  logic [nse_pkg::SKIP_W-1:0]     skip_count,
	input  nse_pkg::cmd_t                  cmd,
	output nse_pkg::sts_t                  sts,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [nse_pkg::EFF_W-1:0]      efficiency,
	output logic [nse_pkg::STAT_W-1:0]     status
);
	import nse_pkg::*;

	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int CMP_W  = (CNT_W > SKIP_W) ? CNT_W : SKIP_W;
	localparam int SAMP_W = (SAMPLE_BITS <= FIELD_W) ? SAMPLE_BITS : FIELD_W + 1;
	localparam int ERR_W  = SAMP_W + 1;
	localparam int OSUM_W = SAMP_W + CNT_W;
	localparam int OSQ_W  = 2 * SAMP_W - 1 + CNT_W;
	localparam int ESQ_W  = 2 * ERR_W - 1 + CNT_W;
	localparam int DEN_W  = CNT_W + OSQ_W;
	localparam int NUM_W  = CNT_W + ESQ_W;
	localparam int X_W    = NUM_W + FRAC_W + 1;
	localparam int STEP_W = $clog2(X_W);

	// sample decode
	logic signed [SAMP_W-1:0] sim_val, obs_val;

	if (SAMPLE_BITS <= FIELD_W) begin : g_signed
		assign sim_val = sim_sample[SAMP_W-1:0];
		assign obs_val = obs_sample[SAMP_W-1:0];
	end else begin : g_unsigned
		assign sim_val = {1'b0, sim_sample};
		assign obs_val = {1'b0, obs_sample};
	end

	logic [CNT_W-1:0]         count_q;
	logic                     acc_en_s1;
	logic signed [SAMP_W-1:0] sim_s1, obs_s1;
	logic signed [OSUM_W-1:0] osum_q;
	logic [OSQ_W-1:0]         osq_q;
	logic [ESQ_W-1:0]         esq_q;

	logic                     in_window, below_cap;
	logic signed [ERR_W-1:0]  err;
	logic signed [2*ERR_W-1:0] err_prod;
	logic signed [2*SAMP_W-1:0] obs_prod;

	assign below_cap = count_q < CNT_W'(MAX_SAMPLES);
	assign in_window = below_cap && (CMP_W'(count_q) >= CMP_W'(skip_count));

	assign err      = ERR_W'(sim_s1) - ERR_W'(obs_s1);
	assign err_prod = err * err;
	assign obs_prod = obs_s1 * obs_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			acc_en_s1 <= 1'b0;
			osum_q    <= '0;
			osq_q     <= '0;
			esq_q     <= '0;
		end else if (cmd.load) begin
			count_q   <= '0;
			acc_en_s1 <= 1'b0;
			osum_q    <= '0;
			osq_q     <= '0;
			esq_q     <= '0;
		end else begin
			acc_en_s1 <= cmd.take && in_window;
			if (cmd.take && below_cap) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (acc_en_s1) begin
				osum_q <= osum_q + OSUM_W'(obs_s1);
				osq_q  <= osq_q + OSQ_W'(obs_prod[2*SAMP_W-2:0]);
				esq_q  <= esq_q + ESQ_W'(err_prod[2*ERR_W-2:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			sim_s1 <= sim_val;
			obs_s1 <= obs_val;
		end
	end

	// final products: N = n*sum(e^2), D = n*sum(o^2) - sum(o)^2
	logic [CMP_W-1:0]            n_wide;
	logic [CNT_W-1:0]            n_val;
	logic signed [2*OSUM_W-1:0]  osum_prod;
	logic [DEN_W-1:0]            a_s2, b_s2, den_q;
	logic [NUM_W-1:0]            num_s2;
	logic                        few_q;

	assign n_wide    = CMP_W'(count_q) - CMP_W'(skip_count);
	assign n_val     = n_wide[CNT_W-1:0];
	assign osum_prod = osum_q * osum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			few_q <= 1'b0;
		end else if (cmd.mul) begin
			few_q <= CMP_W'(count_q) <= CMP_W'(skip_count);
		end
	end

	// D is exact and non-negative, so arithmetic modulo 2^DEN_W is enough
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			a_s2   <= DEN_W'(n_val) * osq_q;
			b_s2   <= DEN_W'(osum_prod);
			num_s2 <= NUM_W'(n_val) * esq_q;
		end
		if (cmd.prep) begin
			den_q <= a_s2 - b_s2;
		end
	end

	// restoring divider, one quotient bit per step, quotient held with a sticky overflow
	logic [X_W-1:0]     x_q;
	logic [DEN_W:0]     rem_q;
	logic [QUOT_W-1:0]  quot_q;
	logic               ovf_q;
	logic [STEP_W-1:0]  step_q;
	logic [DEN_W:0]     rem_shift;
	logic               q_bit;

	assign rem_shift = {rem_q[DEN_W-1:0], x_q[X_W-1]};
	assign q_bit     = rem_shift >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			x_q    <= (X_W'(num_s2) << FRAC_W) + X_W'(den_q >> 1);
			rem_q  <= '0;
			quot_q <= '0;
			ovf_q  <= 1'b0;
			step_q <= '0;
		end else if (cmd.step) begin
			x_q    <= x_q << 1;
			rem_q  <= q_bit ? rem_shift - {1'b0, den_q} : rem_shift;
			quot_q <= {quot_q[QUOT_W-2:0], q_bit};
			ovf_q  <= ovf_q | quot_q[QUOT_W-1];
			step_q <= step_q + STEP_W'(1);
		end
	end

	// result
	logic signed [QUOT_W+1:0] eff_wide;
	logic [EFF_W-1:0]         eff_sat;
	status_t                  stat_nxt;
	logic                     den_zero;

	assign eff_wide = ONE_Q16 - (QUOT_W+2)'(quot_q);
	assign den_zero = den_q == '0;

	always_comb begin
		// quotient is never negative, so only the low end can saturate
		if (ovf_q || eff_wide < EFF_MIN) begin
			eff_sat = EFF_MIN[EFF_W-1:0];
		end else begin
			eff_sat = eff_wide[EFF_W-1:0];
		end
		if (few_q) begin
			stat_nxt = STAT_FEW;
		end else if (den_zero) begin
			stat_nxt = STAT_FLAT;
		end else begin
			stat_nxt = STAT_OK;
		end
	end

	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			efficiency <= (stat_nxt == STAT_OK) ? eff_sat : '0;
			status     <= stat_nxt;
		end
	end

	assign m_tvalid     = out_valid_q;
	assign sts.early    = few_q || den_zero;
	assign sts.div_last = step_q == STEP_W'(X_W - 1);
	assign sts.out_busy = out_valid_q && !m_tready;

endmodule

// File: verif/nse_checker.sv
// Scoreboard for the Nash-Sutcliffe efficiency block: predicts each series result and compares.
`timescale 1ns / 1ps

module nse_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [nse_pkg::IN_DATA_W-1:0]  s_tdata,   // sim_sample, obs_sample
	input  logic                           s_tlast,   // last_pair
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [nse_pkg::EFF_W-1:0]      m_tdata,   // efficiency
	input  logic [nse_pkg::STAT_W-1:0]     m_tuser,   // status
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [nse_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [nse_pkg::APB_DATA_W-1:0] pwdata,
	input  logic                           pready,
	output int                             errors,
	output int                             pending,
	output int                             pairs_seen,
	output int                             ok_seen,
	output int                             few_seen,
	output int                             flat_seen
);
	import nse_pkg::*;

	localparam int SERIES_CAP = MAX_SAMPLES_DEF;
	// quotients at or above this take 1 - N/D to or below the Q8.16 floor
	localparam logic [95:0] QUOT_FLOOR = 96'd8454144;

	typedef struct {
		logic [EFF_W-1:0] efficiency;
		status_t          status;
	} nse_score_t;

	nse_score_t expected_scores[$];
	nse_score_t want;

	logic [SKIP_W-1:0] skip_reg = SKIP_RESET;
	int     counted;
	longint obs_total;
	longint obs_sq_total;
	longint err_sq_total;
	int     fail_count;
	int     pair_total;
	int     status_hits[3];

	task automatic report(input string what, input longint want_v, input longint got_v);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t ns %s: expected %0d, got %0d", $time, what, want_v, got_v);
	endtask

	task automatic clear_series();
		counted = 0;
		obs_total = 0;
		obs_sq_total = 0;
		err_sq_total = 0;
	endtask

	function automatic nse_score_t score_series();
		longint n;
		longint den;
		longint num;
		logic [95:0] dividend;
		logic [95:0] quot;
		nse_score_t r;
		r.efficiency = '0;
		if (counted <= int'(skip_reg)) begin
			r.status = STAT_FEW;
		end else begin
			n = longint'(counted) - longint'(skip_reg);
			den = n * obs_sq_total - obs_total * obs_total;
			if (den == 0) begin
				r.status = STAT_FLAT;
			end else begin
				num = n * err_sq_total;
				// N/D in Q16, halves rounded up
				dividend = (96'(num) << FRAC_W) + 96'(den >>> 1);
				quot = dividend / 96'(den);
				r.status = STAT_OK;
				if (quot >= QUOT_FLOOR)
					r.efficiency = {1'b1, {(EFF_W-1){1'b0}}};
				else
					r.efficiency = EFF_W'(longint'(65536) - longint'(quot));
			end
		end
		return r;
	endfunction

	task automatic absorb_pair();
		longint sv;
		longint ov;
		sv = longint'($signed(s_tdata[FIELD_W-1:0]));
		ov = longint'($signed(s_tdata[IN_DATA_W-1:FIELD_W]));
		pair_total++;
		// pairs past the series cap are dropped entirely
		if (counted < SERIES_CAP) begin
			if (counted >= int'(skip_reg)) begin
				obs_total += ov;
				obs_sq_total += ov * ov;
				err_sq_total += (sv - ov) * (sv - ov);
			end
			counted++;
		end
		if (s_tlast) begin
			expected_scores.insert(expected_scores.size(), score_series());
			clear_series();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_scores.delete();
			skip_reg = SKIP_RESET;
			clear_series();
		end else begin
			if (m_tvalid && m_tready) begin
				if (m_tuser <= STAT_W'(STAT_FLAT))
					status_hits[m_tuser]++;
				if (expected_scores.size() == 0) begin
					report("result transaction with nothing expected, efficiency",
						0, longint'($signed(m_tdata)));
				end else begin
					want = expected_scores.pop_front();
					if (m_tdata !== want.efficiency)
						report("efficiency", longint'($signed(want.efficiency)),
							longint'($signed(m_tdata)));
					if (m_tuser !== want.status)
						report("status", longint'(want.status), longint'(m_tuser));
				end
			end
			// a register write only counts for the pairs after it
			if (s_tvalid && s_tready)
				absorb_pair();
			if (psel && penable && pwrite && pready &&
				paddr[APB_ADDR_W-1:2] == REG_SKIP_COUNT)
				skip_reg = pwdata[SKIP_W-1:0];
		end
		pending    <= expected_scores.size();
		errors     <= fail_count;
		pairs_seen <= pair_total;
		ok_seen    <= status_hits[STAT_OK];
		few_seen   <= status_hits[STAT_FEW];
		flat_seen  <= status_hits[STAT_FLAT];
	end

endmodule

// File: verif/nash_sutcliffe_efficiency_top_tb.sv
// Stimulus and verdict for the Nash-Sutcliffe efficiency block.
`timescale 1ns / 1ps

module nash_sutcliffe_efficiency_top_tb;
	import nse_pkg::*;

	localparam int DRAIN_CYCLES = 80;
	localparam int TIMEOUT_NS = 20_000_000;
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 1'b1;
	localparam logic [FIELD_W-1:0] SAMPLE_MIN = 16'h8000;
	localparam logic [FIELD_W-1:0] SAMPLE_MAX = 16'h7FFF;

	typedef enum {FIT_CLOSE, FIT_WILD, FIT_FLAT} fit_t;
	typedef enum {RX_OPEN, RX_JITTER, RX_CHOKE} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // sim_sample, obs_sample
	logic                  s_tlast = 1'b0; // last_pair
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [EFF_W-1:0]      m_tdata;        // efficiency
	logic [STAT_W-1:0]     m_tuser;        // status
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int errors;
	int pending;
	int pairs_seen;
	int ok_seen;
	int few_seen;
	int flat_seen;

	int burst_left = 0;
	int phase_pairs = 0;
	int settings_used = 0;
	rx_mode_t rx_mode = RX_OPEN;
	int rx_left = 0;

	always #5 clk = ~clk;

	nash_sutcliffe_efficiency_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	nse_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.errors     (errors),
		.pending    (pending),
		.pairs_seen (pairs_seen),
		.ok_seen    (ok_seen),
		.few_seen   (few_seen),
		.flat_seen  (flat_seen)
	);

	// result side: open, jittery and choked stretches
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 2));
			rx_left <= $urandom_range(16, 128);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN: m_tready <= 1'b1;
			RX_JITTER: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	function automatic logic [FIELD_W-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return SAMPLE_MIN;
			1: return SAMPLE_MAX;
			2: return FIELD_W'($urandom_range(0, 255)) - FIELD_W'(128);
			default: return FIELD_W'($urandom());
		endcase
	endfunction

	task automatic push_pair(input logic [FIELD_W-1:0] sim, input logic [FIELD_W-1:0] obs,
		input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			burst_left = $urandom_range(1, 40);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= {obs, sim};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		phase_pairs++;
	endtask

	// hold off until every series result has been taken
	task automatic settle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] val);
		repeat (DRAIN_CYCLES) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// junk in the bits above the field
	task automatic set_skip(input int k);
		write_reg(REG_SKIP_COUNT, ($urandom() & ~32'h1FF) | APB_DATA_W'(k));
		settings_used++;
	endtask

	task automatic run_series(input int len, input fit_t how);
		logic [FIELD_W-1:0] obs;
		logic [FIELD_W-1:0] sim;
		logic [FIELD_W-1:0] level;
		level = rand_sample();
		for (int i = 0; i < len; i++) begin
			case (how)
				FIT_CLOSE: begin
					obs = rand_sample();
					sim = obs + FIELD_W'($urandom_range(0, 256)) - FIELD_W'(128);
				end
				FIT_FLAT: begin
					obs = level;
					sim = rand_sample();
				end
				default: begin
					obs = rand_sample();
					sim = rand_sample();
				end
			endcase
			push_pair(sim, obs, 1'(i == len - 1));
		end
	endtask

	// mostly series that reach past the skipped pairs, some that stop short
	task automatic random_phase(input int k, input int budget);
		int len;
		int pick;
		fit_t how;
		set_skip(k);
		phase_pairs = 0;
		while (phase_pairs < budget) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				len = $urandom_range(1, (k > 0) ? k : 1);
			else if (pick == 1)
				len = k + 1;
			else
				len = k + $urandom_range(2, 24);
			pick = $urandom_range(0, 9);
			how = (pick < 6) ? FIT_CLOSE : (pick < 9) ? FIT_WILD : FIT_FLAT;
			run_series(len, how);
			if ($urandom_range(0, 11) == 0)
				settle();
		end
		settle();
	endtask

	initial begin
		#(TIMEOUT_NS);
		$display("nash_sutcliffe_efficiency_top_tb: errors");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// skip of 50 out of reset: a short series is too few
		push_pair(16'h0001, 16'h0002, 1'b0);
		push_pair(16'hFFFE, 16'h0100, 1'b0);
		push_pair(16'h0003, 16'hFF00, 1'b1);
		settle();
		write_reg(REG_SPARE, 32'hFFFF_FFFF);

		set_skip(0);
		push_pair(SAMPLE_MIN, SAMPLE_MIN, 1'b1);          // one counted pair
		push_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b0);          // exact fit
		push_pair(SAMPLE_MIN, SAMPLE_MIN, 1'b1);
		push_pair(SAMPLE_MIN, 16'h0000, 1'b0);            // huge error, tiny variance
		push_pair(SAMPLE_MAX, 16'h0001, 1'b1);
		push_pair(16'h0064, 16'h0005, 1'b0);              // constant observations
		push_pair(16'h0005, 16'h0005, 1'b0);
		push_pair(16'h0005, 16'h0005, 1'b1);
		push_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
		push_pair(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
		push_pair(16'h0000, 16'h0000, 1'b1);
		settle();

		set_skip(2);
		push_pair(16'h0001, 16'h0002, 1'b0);              // length equals skip
		push_pair(16'h0003, 16'h0004, 1'b1);
		push_pair(16'h0001, 16'h0002, 1'b0);
		push_pair(16'h0003, 16'h0004, 1'b0);
		push_pair(16'h0005, 16'h0006, 1'b1);
		settle();

		random_phase(0, 160);
		// full-scale observations over the whole cap, then past it
		for (int i = 0; i < 516; i++)
			push_pair(rand_sample(), SAMPLE_MIN, 1'(i == 515));
		run_series(520, FIT_CLOSE);
		settle();

		random_phase(1, 160);
		random_phase($urandom_range(3, 20), 160);
		set_skip(511);
		repeat (4) run_series($urandom_range(1, 40), FIT_WILD);
		settle();
		random_phase(50, 160);
		random_phase($urandom_range(0, 7), 160);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d pairs in %0d series under %0d skip settings",
			pairs_seen, ok_seen + few_seen + flat_seen, settings_used);
		$display("Outcomes: %0d scored, %0d too short, %0d flat", ok_seen, few_seen, flat_seen);
		if (errors == 0 && pending == 0)
			$display("nash_sutcliffe_efficiency_top_tb: clean");
		else
			$display("nash_sutcliffe_efficiency_top_tb: errors");
		$finish;
	end

endmodule
